>>> sv/mcstb_pkg.sv
// Shared types and constants for the soft timer bank.
// Used by mcstb_ctrl, mcstb_dp and multi_channel_soft_timer_bank; no dependencies.
package mcstb_pkg;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int FIRE_CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int ACT_W   = 2;
  localparam int CH_IN_W = 8;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int FCH_W   = 6;

  localparam logic [CFG_W-1:0] BASE_OFFSET_RST = 16'd200;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_START  = 2'd1,
    ACT_CANCEL = 2'd2,
    ACT_NOP    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    CH_ARMED   = 2'd0,
    CH_EXPIRED = 2'd1,
    CH_STOPPED = 2'd2
  } chan_st_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_tick;
    logic scan_end;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/mcstb_ctrl.sv
// Sequencing state machine of the soft timer bank.
// Depends on mcstb_pkg; drives mcstb_dp through dp_cmd_t and reads dp_sts_t.
module mcstb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output mcstb_pkg::dp_cmd_t cmd,
  input  mcstb_pkg::dp_sts_t sts
);
  import mcstb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.in_tick ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

  always_comb begin
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.exec   = (state == S_EXEC);
    cmd.scan   = (state == S_SCAN);
    cmd.finish = (state == S_DONE);
  end

endmodule

>>> sv/mcstb_dp.sv
// Datapath of the soft timer bank: channel flags, match and period memories,
// scan index, pending fire and output register. Depends on mcstb_pkg.
module mcstb_dp #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcstb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [mcstb_pkg::ACT_W-1:0]   action,
  input  logic [mcstb_pkg::CH_IN_W-1:0] channel,
  input  logic                          repeat_mode,
  input  logic [mcstb_pkg::TIME_W-1:0]  delay_ms,
  input  logic [mcstb_pkg::TIME_W-1:0]  now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fired,
  output logic [mcstb_pkg::FCH_W-1:0]   fired_channel,
  output logic                          status,
  output logic                          last,
  input  mcstb_pkg::dp_cmd_t            cmd,
  output mcstb_pkg::dp_sts_t            sts
);
  import mcstb_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0]    LAST_CH   = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CH_IN_W-1:0] NUM_CH_IN = CH_IN_W'(NUM_CHANNELS);

  // Latched transaction.
  act_t               act_q;
  logic [CH_IN_W-1:0] ch_q;
  logic               mode_q;
  logic               dly_zero_q;
  logic [TIME_W-1:0]  dly_adj_q;
  logic [TIME_W-1:0]  now_q;

  logic [CFG_W-1:0]   base_offset;

  chan_st_t           chan_state [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_periodic;

  logic [TIME_W-1:0]  match_mem  [NUM_CHANNELS];
  logic [TIME_W-1:0]  period_mem [NUM_CHANNELS];
  logic [TIME_W-1:0]  match_rd;
  logic [TIME_W-1:0]  period_rd;

  logic [CH_W-1:0]       idx;
  logic                  pend_valid;
  logic [CH_W-1:0]       pend_ch;
  logic [FIRE_CNT_W-1:0] fire_cnt;

  logic               out_free;
  logic               ch_ok;
  logic [CH_W-1:0]    ch_sel;
  logic               reject;
  logic               exec_go;
  logic               start_go;
  logic               cancel_go;
  chan_st_t           cur_st;
  logic               fire_now;
  logic               expire_now;
  logic               step;
  logic               emit_mid;
  logic               finish_go;
  logic [CH_W-1:0]    idx_nx;
  logic               rd_en;
  logic [CH_W-1:0]    rd_addr;
  logic               m_we;
  logic [CH_W-1:0]    m_addr;
  logic [TIME_W-1:0]  m_wdata;

  always_comb begin
    out_free  = !out_valid || out_ready;
    ch_ok     = (ch_q < NUM_CH_IN);
    ch_sel    = ch_q[CH_W-1:0];
    case (act_q)
      ACT_START:  reject = !ch_ok || dly_zero_q;
      ACT_CANCEL: reject = !ch_ok;
      default:    reject = 1'b0;
    endcase
    exec_go   = cmd.exec && out_free;
    start_go  = exec_go && (act_q == ACT_START) && !reject;
    cancel_go = exec_go && (act_q == ACT_CANCEL) && !reject;

    cur_st     = chan_state[idx];
    fire_now   = cmd.scan && (cur_st == CH_EXPIRED) &&
                 (fire_cnt < FIRE_CNT_W'(MAX_RESULTS));
    expire_now = cmd.scan && (cur_st == CH_ARMED) && (match_rd < now_q);
    // A second fire can only be taken once the previous one has left.
    step       = cmd.scan && !(fire_now && pend_valid && !out_free);
    emit_mid   = step && fire_now && pend_valid;
    finish_go  = cmd.finish && out_free;

    idx_nx  = (idx == LAST_CH) ? '0 : idx + 1'b1;
    rd_en   = !cmd.scan || step;
    rd_addr = cmd.scan ? idx_nx : '0;

    m_we    = start_go || (step && fire_now);
    m_addr  = start_go ? ch_sel : idx;
    m_wdata = start_go ? (now_q + dly_adj_q) : (now_q + period_rd);

    sts.in_tick  = (action == ACT_TICK);
    sts.scan_end = step && (idx == LAST_CH);
    sts.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      match_mem[m_addr] <= m_wdata;
    end
    if (start_go) begin
      period_mem[ch_sel] <= dly_adj_q;
    end
    if (rd_en) begin
      match_rd  <= match_mem[rd_addr];
      period_rd <= period_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q      <= act_t'(action);
      ch_q       <= channel;
      mode_q     <= repeat_mode;
      dly_zero_q <= (delay_ms == '0);
      dly_adj_q  <= delay_ms - TIME_W'(base_offset);
      now_q      <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= BASE_OFFSET_RST;
    end else if (cfg_we) begin
      base_offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_state[i] <= CH_STOPPED;
      end
      chan_periodic <= '0;
    end else begin
      if (start_go) begin
        chan_state[ch_sel]    <= CH_ARMED;
        chan_periodic[ch_sel] <= mode_q;
      end
      if (cancel_go) begin
        chan_state[ch_sel] <= CH_STOPPED;
      end
      if (expire_now) begin
        chan_state[idx] <= CH_EXPIRED;
      end
      if (step && fire_now) begin
        chan_state[idx] <= chan_periodic[idx] ? CH_ARMED : CH_STOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
      fire_cnt   <= '0;
    end else begin
      if (step) begin
        idx <= idx_nx;
        if (fire_now) begin
          pend_valid <= 1'b1;
          pend_ch    <= idx;
          fire_cnt   <= fire_cnt + 1'b1;
        end
      end
      if (finish_go) begin
        pend_valid <= 1'b0;
        fire_cnt   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go || emit_mid || finish_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      fired         <= 1'b0;
      fired_channel <= '0;
      status        <= reject;
      last          <= 1'b1;
    end else if (emit_mid) begin
      fired         <= 1'b1;
      fired_channel <= FCH_W'(pend_ch);
      status        <= 1'b0;
      last          <= 1'b0;
    end else if (finish_go) begin
      fired         <= pend_valid;
      fired_channel <= pend_valid ? FCH_W'(pend_ch) : '0;
      status        <= 1'b0;
      last          <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_idx_home: assert property (@(posedge clk) disable iff (rst)
    !cmd.scan |-> (idx == '0))
    else $error("scan index not parked at zero outside a tick scan");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    (!cmd.scan && !cmd.finish) |-> !pend_valid)
    else $error("pending fire left over outside a tick");

  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FIRE_CNT_W'(MAX_RESULTS))
    else $error("fire count above the per-tick limit");

  a_mid_is_fire: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (fired && !status))
    else $error("non-final result that is not a fire");
`endif

endmodule

>>> sv/multi_channel_soft_timer_bank.sv
// Top level of the soft timer bank: controller plus datapath.
// Depends on mcstb_pkg, mcstb_ctrl and mcstb_dp.
//
//   channel   handshake             payload
//   -------   -------------------   -------------------------------------------
//   input     in_valid / in_ready   action, channel, repeat_mode, delay_ms, now_ms
//   output    out_valid / out_ready fired, fired_channel, status, last
//   config    cfg_we                cfg_wdata (base_offset)
//
// A start, cancel or no-op is captured, then executed and its result loaded.
// A tick scans one channel per cycle, unless a stalled output holds the scan, through
// the single read port of the match and period memories, then loads the closing result.
// A stalled output holds the scan only when a second fire has to leave while the first
// still waits; the next transaction is taken once the last result is loaded.
// Reset is synchronous; channel flags reset to stopped, so the memories need no clearing.
module multi_channel_soft_timer_bank #(
  parameter int NUM_CHANNELS = mcstb_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mcstb_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcstb_pkg::ACT_W-1:0]   action,
  input  logic [mcstb_pkg::CH_IN_W-1:0] channel,
  input  logic                          repeat_mode,
  input  logic [mcstb_pkg::TIME_W-1:0]  delay_ms,
  input  logic [mcstb_pkg::TIME_W-1:0]  now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fired,
  output logic [mcstb_pkg::FCH_W-1:0]   fired_channel,
  output logic                          status,
  output logic                          last
);
  import mcstb_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller decides which phase the current transaction is in and drives in_ready.
  mcstb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds all timer state and builds every result.
  mcstb_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .action        (action),
    .channel       (channel),
    .repeat_mode   (repeat_mode),
    .delay_ms      (delay_ms),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fired         (fired),
    .fired_channel (fired_channel),
    .status        (status),
    .last          (last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
